[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// constants, types and round functions shared by the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS = 16;
  localparam int ROUNDS = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef enum logic [3:0] {
    ST_IDLE,    // accept bytes
    ST_LOAD,    // copy 16 words from buffer into schedule
    ST_ROUND,   // 64 rounds
    ST_ADD,     // fold working vars into hash
    ST_PAD,     // write padding bytes one per cycle
    ST_OUT      // emit digest words
  } state_t;

  // why a compression was started
  typedef enum logic [1:0] {
    CM_FILL,
    CM_PAD1,
    CM_FINAL
  } cmode_t;

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[design/sha_ram.sv]
// ----------------------------------------------------------------------------
// sha_ram
// generic single-port-write, one-read ram with registered read data
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core
// one sha-256 round per cycle while round_en is high, with a rolling 16-word message schedule
// ----------------------------------------------------------------------------
module sha_core (
  input  logic        clk,
  input  logic        load_en,    // shift in a schedule word
  input  logic [31:0] load_word,
  input  logic        init,       // take working vars from hash
  input  logic        round_en,
  input  logic [5:0]  round_idx,
  input  logic [255:0] hash_in,
  output logic [255:0] work_out
);

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] s0, s1, wnew, wcur, t1, t2;

  always_comb begin
    s0 = sha_pkg::rotr(w[1], 7) ^ sha_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::rotr(w[14], 17) ^ sha_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    wcur = w[0];
    t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + sha_pkg::k_const(round_idx) + wcur;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
  end

  // w[0] is the word used by the current round
  always_ff @(posedge clk) begin
    if (load_en || round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= load_en ? load_word : wnew;
    end
    if (init) begin
      {a, b, c, d, e, f, g, h} <= hash_in;
    end else if (round_en) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  assign work_out = {a, b, c, d, e, f, g, h};

endmodule

[design/sha256_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-serial sha-256 hasher, block buffer in a ram
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries one request per message byte
//   (byte_valid) and optionally end_of_message. output channel
//   out_valid/out_stall gives the eight digest words, index 0 first,
//   last_word on index 7.
//   bytes are taken one per cycle while in_stall is low; the 64th byte of a
//   block starts a compression: a load phase reads the buffer one byte at
//   a time into 16 schedule words, then 64 rounds run, then the working
//   vars are folded into the hash, paced by the single round unit and the
//   one-read buffer ram. an end request sweeps the 64 buffer positions
//   one per cycle, rewriting those from fill onward, runs one or two
//   compressions, then emits 8 words, one per cycle unless stalled. two
//   compressions run when the padding spills into a second block or when
//   the end request carries the 64th byte of a block.
//   input stall is high throughout any compression, padding or output.
//   a stalled output word holds until taken; afterwards the block returns
//   to its reset state for the next message.
//   reset (rst, synchronous) restores the initial hash and clears counts;
//   the buffer ram needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha_pkg::state_t state, state_next;
  sha_pkg::cmode_t cmode;
  logic [255:0] hash;
  logic [5:0]  fill;
  logic [63:0] total;
  logic [6:0]  cnt;        // load/round/pad counter
  logic [2:0]  oidx;
  logic        pend_end;   // end seen with a block-filling byte; also marks a second pad block

  logic        we;
  logic [5:0]  waddr, raddr;
  logic [7:0]  wdata, rdata;
  logic [31:0] lword;
  logic [255:0] work;
  logic        acc;
  logic [63:0] bits;

  assign acc = in_valid && !in_stall;
  assign bits = total << 3;

  sha_ram #(.WIDTH(8), .DEPTH(sha_pkg::BLOCK_BYTES)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // load reads 4 bytes per word: cnt counts byte reads 0..63, data in the next cycle
  logic        load_word_en;
  logic        init_core, round_en;
  assign raddr = cnt[5:0];

  sha_core u_core (
    .clk(clk), .load_en(load_word_en), .load_word(lword), .init(init_core),
    .round_en(round_en), .round_idx(cnt[5:0]), .hash_in(hash), .work_out(work)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (acc && byte_valid && fill == 6'd63) begin
          state_next = sha_pkg::ST_LOAD;
        end else if (acc && end_of_message) begin
          state_next = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_LOAD:  if (cnt == 7'd64) state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (cnt == 7'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        case (cmode)
          sha_pkg::CM_FILL:  state_next = pend_end ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
          sha_pkg::CM_PAD1:  state_next = sha_pkg::ST_PAD;
          sha_pkg::CM_FINAL: state_next = sha_pkg::ST_OUT;
          default:           state_next = sha_pkg::ST_IDLE;
        endcase
      end
      sha_pkg::ST_PAD: begin
        if (cnt[5:0] == 6'd63) begin
          state_next = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_OUT:   if (!out_stall && oidx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default:           state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != sha_pkg::ST_IDLE);
    we = 1'b0;
    waddr = fill;
    wdata = data_byte;
    load_word_en = 1'b0;
    init_core = 1'b0;
    round_en = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: we = acc && byte_valid;
      sha_pkg::ST_LOAD: begin
        load_word_en = (cnt != 7'd0) && (cnt[1:0] == 2'd0);
        init_core = (cnt == 7'd64);
      end
      sha_pkg::ST_ROUND: round_en = 1'b1;
      sha_pkg::ST_PAD: begin
        // cnt sweeps the whole block position; bytes before fill untouched
        we = (cnt[5:0] >= fill);
        waddr = cnt[5:0];
        // pad byte in the second block of a two-block finish must not be written:
        // pend_end marks that block, so fill = 0 there gets zero instead
        if (cnt[5:0] == fill && !pend_end) begin
          wdata = sha_pkg::PAD_BYTE;
        end else if (cmode == sha_pkg::CM_FINAL && cnt[5:0] >= sha_pkg::LEN_POS) begin
          wdata = bits[8*(7 - int'(cnt[2:0])) +: 8];
        end else begin
          wdata = 8'h00;
        end
      end
      default: ;
    endcase
  end

  // assemble schedule word from registered byte reads
  logic [23:0] lsh;
  assign lword = {lsh, rdata};

  always_ff @(posedge clk) begin
    if (state == sha_pkg::ST_LOAD) begin
      lsh <= {lsh[15:0], rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        hash[255-32*i -: 32] <= sha_pkg::h_init(3'(i));
      end
      fill <= '0;
      total <= '0;
      cnt <= '0;
      oidx <= '0;
      pend_end <= 1'b0;
      cmode <= sha_pkg::CM_FILL;
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::ST_IDLE: begin
          cnt <= '0;
          if (acc) begin
            if (byte_valid) begin
              fill <= fill + 6'd1;
              total <= total + 64'd1;
            end
            pend_end <= end_of_message && byte_valid && fill == 6'd63;
            cmode <= sha_pkg::CM_FILL;
            if (end_of_message && !(byte_valid && fill == 6'd63)) begin
              // decide pad mode: fill after this byte
              cmode <= ((byte_valid ? fill + 6'd1 : fill) > 6'd55) ?
                       sha_pkg::CM_PAD1 : sha_pkg::CM_FINAL;
              if (byte_valid) fill <= fill + 6'd1;
            end
          end
        end
        sha_pkg::ST_LOAD: cnt <= (cnt == 7'd64) ? 7'd0 : cnt + 7'd1;
        sha_pkg::ST_ROUND: cnt <= cnt + 7'd1;
        sha_pkg::ST_ADD: begin
          cnt <= '0;
          for (int i = 0; i < 8; i++) begin
            hash[255-32*i -: 32] <= hash[255-32*i -: 32] + work[255-32*i -: 32];
          end
          if (cmode == sha_pkg::CM_FILL && pend_end) begin
            pend_end <= 1'b0;
            fill <= '0;
            cmode <= sha_pkg::CM_FINAL;
          end else if (cmode == sha_pkg::CM_PAD1) begin
            // second block: all zero plus length, pad byte already placed
            cmode <= sha_pkg::CM_FINAL;
            fill <= '0;
            pend_end <= 1'b1;
          end
          oidx <= '0;
        end
        sha_pkg::ST_PAD: begin
          cnt <= cnt + 7'd1;
          if (cnt[5:0] == 6'd63) cnt <= '0;
        end
        sha_pkg::ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[255-32*i -: 32] <= sha_pkg::h_init(3'(i));
              end
              fill <= '0;
              total <= '0;
              pend_end <= 1'b0;
              cmode <= sha_pkg::CM_FILL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == sha_pkg::ST_OUT);
  assign digest_word = hash[255 - 32*int'(oidx) -: 32];
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

endmodule

[design/sha_checker.sv]
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks on the hasher handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic [31:0] digest_word
);
  logic       take;
  logic [2:0] idx_inc;

  assign take = out_valid && !out_stall;
  assign idx_inc = word_index + 3'd1;

  `CHK_IMPL(a_last, clk, rst, out_valid, last_word == (word_index == 3'd7), "last_word mismatch")
  `CHK_IMPL(a_busy, clk, rst, out_valid && in_valid, in_stall, "input open during output")
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(digest_word), "word changed")
  `CHK_NEXT(a_step, clk, rst, take && !last_word, word_index == $past(idx_inc), "word order broken")
endmodule

bind sha256_stream_hasher_top sha_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
  .last_word(last_word), .digest_word(digest_word)
);

[bench/sha256_stream_hasher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_tb
// checks byte-serial sha-256 digests against an in-bench hash of each message
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_tb;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // digest scoreboard: keeps its own running hash state
  class digest_scoreboard;
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] nbytes;
    digest_out_t pending [$];
    int errors;
    int words_seen;
    int messages;

    function new();
      errors = 0;
      words_seen = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill = 0;
      nbytes = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
      e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + sha_pkg::k_const(i[5:0]) + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
      hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function void note_request(logic [7:0] db, logic bv, logic eom);
      logic [63:0] bits;
      int unsigned p;
      digest_out_t o;
      if (bv) begin
        blk[fill] = db;
        fill++;
        nbytes++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
      end
      if (!eom) return;
      bits = nbytes << 3;
      p = fill;
      blk[p] = sha_pkg::PAD_BYTE;
      p++;
      if (p > 56) begin
        while (p < 64) begin blk[p] = 8'h00; p++; end
        compress_block();
        p = 0;
      end
      while (p < 56) begin blk[p] = 8'h00; p++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hv[i];
        o.word_index = i[2:0];
        o.last_word = (i == 7);
        pending.insert(pending.size(), o);
      end
      messages++;
      restart();
    endfunction

    function void check_word(digest_out_t got);
      digest_out_t want;
      words_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected digest word %h idx %0d last %0b",
                   got.digest_word, got.word_index, got.last_word);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                   want.digest_word, want.word_index, want.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;
  digest_scoreboard sb;

  sha256_stream_hasher_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall, check on every accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word({digest_word, word_index, last_word});
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one request, held until accepted; valid stays up for a following request
  task automatic send_request(logic [7:0] db, logic bv, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= db;
    byte_valid <= bv;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(db, bv, eom);
    requests_sent++;
  endtask

  task automatic send_message(int len, bit trailing_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, 1'b0);
    end
    send_request(8'($urandom_range(255)), trailing_byte, 1'b1);
  endtask

  task automatic set_phase(int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty message, idle item, one byte each extreme, end in its own request
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'ha5, 1'b0, 1'b1);
    // random messages; lengths around the 55/56/64 padding boundaries, plus short ones
    for (int ph = 0; ph < 4; ph++) begin
      int phase_start;
      case (ph)
        0: begin set_phase(0, 0); end
        1: begin set_phase(80, 0); end
        2: begin set_phase(0, 80); end
        default: begin set_phase(12, 12); end
      endcase
      phase_start = requests_sent;
      while (requests_sent - phase_start < 60) begin
        case ($urandom_range(5))
          0: begin send_message($urandom_range(54, 57), 1'($urandom_range(1))); end
          1: begin send_message($urandom_range(62, 65), 1'($urandom_range(1))); end
          2: begin send_message($urandom_range(0, 3), 1'($urandom_range(1))); end
          default: begin send_message($urandom_range(0, 20), 1'($urandom_range(1))); end
        endcase
      end
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests in %0d messages, checked %0d digest words",
             requests_sent, sb.messages, sb.words_seen);
    $display("covered empty, idle, padding-boundary messages under four idle/stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/sha_pkg.sv
design/sha_ram.sv
design/sha_core.sv
design/sha256_stream_hasher_top.sv
design/sha_checker.sv
bench/sha256_stream_hasher_top_tb.sv
